@@ sv/msc_pkg.sv @@
package msc_pkg;

	localparam int SET_BITS_D    = 6;
	localparam int WAYS_D        = 2;
	localparam int OFFSET_BITS_D = 5;
	localparam int ADDR_BITS_D   = 32;

	localparam int ID_W   = 4;
	localparam int CNT_W  = 32;
	localparam int IN_W   = 72;
	localparam int OUT_W  = 240;
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		ACT_PROC  = 2'd0,
		ACT_SNOOP = 2'd1,
		ACT_FILL  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_I = 2'd0,
		ST_S = 2'd1,
		ST_E = 2'd2,
		ST_M = 2'd3
	} mesi_t;

	localparam logic [1:0] REQ_RD  = 2'd0;
	localparam logic [1:0] REQ_RDX = 2'd1;
	localparam logic [1:0] REQ_WB  = 2'd2;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} bk_state_t;

	// last field in the lowest bits
	typedef struct packed {
		logic        pad;
		logic [1:0]  fill_state;
		logic [31:0] current_cycle;
		logic [31:0] address;
		logic [1:0]  snoop_kind;
		logic        is_write;
		logic [1:0]  action;
	} item_t;

	typedef struct packed {
		logic [6:0]       pad;
		logic [CNT_W-1:0] invalidation_count;
		logic [CNT_W-1:0] writeback_count;
		logic [CNT_W-1:0] eviction_count;
		logic [CNT_W-1:0] miss_count;
		logic [CNT_W-1:0] hit_count;
		logic [31:0]      ready_cycle;
		logic             blocked;
		logic [ID_W-1:0]  bus_req_source;
		logic [31:0]      bus_req_addr;
		logic [1:0]       bus_req_kind;
		logic             bus_req_valid;
		logic             access_done;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
		sat_inc = (en && v != '1) ? v + CNT_W'(1) : v;
	endfunction

endpackage

@@ sv/msc_ram.sv @@
module msc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sv/msc_front.sv @@
module msc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [msc_pkg::IN_W-1:0]   s_axis_tdata,
	input  logic                       pop,
	output logic                       q_valid,
	output msc_pkg::item_t             q_item
);
	import msc_pkg::*;

	item_t      mem_q [QDEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      in_item;

	assign in_item       = item_t'(s_axis_tdata);
	assign s_axis_tready = cnt_q != 2'(QDEPTH);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = cnt_q != 2'd0;
	assign q_item        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

@@ sv/msc_back.sv @@
module msc_back #(
	parameter int SET_BITS    = msc_pkg::SET_BITS_D,
	parameter int WAYS        = msc_pkg::WAYS_D,
	parameter int OFFSET_BITS = msc_pkg::OFFSET_BITS_D,
	parameter int ADDR_BITS   = msc_pkg::ADDR_BITS_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  msc_pkg::item_t             q_item,
	output logic                       pop,
	input  logic [msc_pkg::ID_W-1:0]   cache_id,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [msc_pkg::OUT_W-1:0]  m_axis_tdata
);
	import msc_pkg::*;

	localparam int AW        = ADDR_BITS < 32 ? ADDR_BITS : 32;
	localparam int TAG_SHIFT = SET_BITS + OFFSET_BITS;
	localparam int TAG_W     = AW > TAG_SHIFT ? AW - TAG_SHIFT : 1;
	localparam int SET_W     = SET_BITS > 0 ? SET_BITS : 1;
	localparam int NSETS     = 1 << SET_BITS;
	localparam int LINE_W    = TAG_W + 2 + 32;
	localparam int ROW_W     = WAYS * LINE_W;
	localparam int WAY_W     = WAYS > 1 ? $clog2(WAYS) : 1;
	localparam logic [32:0]    AM_FULL = (33'd1 << AW) - 33'd1;
	localparam logic [31:0]    AMASK   = AM_FULL[31:0];
	localparam logic [SET_W:0] SM_FULL = (SET_W+1)'((1 << SET_BITS) - 1);
	localparam logic [SET_W-1:0] SMASK = SM_FULL[SET_W-1:0];

	function automatic logic [SET_W-1:0] set_of(input logic [31:0] a);
		logic [31:0] s;
		s      = (a & AMASK) >> OFFSET_BITS;
		set_of = s[SET_W-1:0] & SMASK;
	endfunction

	bk_state_t        state_q, state_d;
	logic             exec;
	item_t            item_s1;
	logic [SET_W-1:0] set_s1;
	logic [NSETS-1:0] row_valid_q;
	logic [ROW_W-1:0] rdata, row, wrow;
	logic             blocked_q, blocked_d;
	logic [31:0]      ready_q, ready_d;
	logic [CNT_W-1:0] cnt_q [5];
	logic [CNT_W-1:0] cnt_d [5];
	logic             out_valid_q;
	result_t          out_q, res;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (q_valid && !out_valid_q) state_d = BK_EXEC;
			BK_EXEC: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		exec = 1'b0;
		case (state_q)
			BK_IDLE: pop = q_valid && !out_valid_q;
			BK_EXEC: exec = 1'b1;
			default: ;
		endcase
	end

	msc_ram #(.WIDTH(ROW_W), .DEPTH(NSETS)) u_ram (
		.clk  (clk),
		.we   (exec),
		.waddr(set_s1),
		.wdata(wrow),
		.re   (pop),
		.raddr(set_of(q_item.address)),
		.rdata(rdata)
	);

	logic [TAG_W-1:0] tag_w  [WAYS];
	logic [1:0]       st_w   [WAYS];
	logic [31:0]      lu_w   [WAYS];
	logic [TAG_W-1:0] ntag_w [WAYS];
	logic [1:0]       nst_w  [WAYS];
	logic [31:0]      nlu_w  [WAYS];
	logic [31:0]      addr_m, tag_full, cyc;
	logic [TAG_W-1:0] itag;
	logic             hit, req, done;
	logic [WAY_W-1:0] hw, lw, vi;
	logic [31:0]      lt, raddr;
	logic [1:0]       rkind;
	logic [63:0]      wb64;
	logic [4:0]       bump;

	always_comb begin
		row      = row_valid_q[set_s1] ? rdata : '0;
		addr_m   = item_s1.address & AMASK;
		tag_full = addr_m >> TAG_SHIFT;
		itag     = tag_full[TAG_W-1:0];
		cyc      = item_s1.current_cycle;
		hit      = 1'b0;
		hw       = '0;
		lw       = '0;
		for (int w = 0; w < WAYS; w++) begin
			{lu_w[w], st_w[w], tag_w[w]} = row[w*LINE_W +: LINE_W];
			ntag_w[w] = tag_w[w];
			nst_w[w]  = st_w[w];
			nlu_w[w]  = lu_w[w];
		end
		lt = lu_w[0];
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && st_w[w] != ST_I && tag_w[w] == itag) begin
				hit = 1'b1;
				hw  = WAY_W'(w);
			end
		end
		for (int w = 1; w < WAYS; w++) begin
			if (lu_w[w] < lt) begin
				lt = lu_w[w];
				lw = WAY_W'(w);
			end
		end
		vi        = hit ? hw : lw;
		wb64      = (64'(tag_w[vi]) << TAG_SHIFT) | (64'(set_s1) << OFFSET_BITS);
		req       = 1'b0;
		done      = 1'b0;
		rkind     = REQ_RD;
		raddr     = addr_m;
		bump      = '0;
		blocked_d = blocked_q;
		ready_d   = ready_q;
		case (action_t'(item_s1.action))
			ACT_PROC: begin
				if (hit) begin
					bump[0]    = 1'b1;
					nlu_w[hw]  = cyc;
					done       = 1'b1;
					if (item_s1.is_write) begin
						if (st_w[hw] == ST_E) begin
							nst_w[hw] = ST_M;
						end else if (st_w[hw] == ST_S) begin
							req       = 1'b1;
							rkind     = REQ_RDX;
							blocked_d = 1'b1;
							ready_d   = cyc + 32'd1;
							done      = 1'b0;
						end
					end
				end else begin
					bump[1]   = 1'b1;
					blocked_d = 1'b1;
					req       = 1'b1;
					rkind     = item_s1.is_write ? REQ_RDX : REQ_RD;
				end
			end
			ACT_SNOOP: begin
				if (hit) begin
					nlu_w[hw] = cyc;
					if (item_s1.snoop_kind == REQ_RD) begin
						if (st_w[hw] == ST_M) begin
							req   = 1'b1;
							rkind = REQ_WB;
						end
						if (st_w[hw] == ST_M || st_w[hw] == ST_E) nst_w[hw] = ST_S;
					end else if (item_s1.snoop_kind == REQ_RDX) begin
						if (st_w[hw] == ST_M) begin
							req   = 1'b1;
							rkind = REQ_WB;
						end
						nst_w[hw] = ST_I;
						bump[4]   = 1'b1;
					end
				end
			end
			ACT_FILL: begin
				if (!hit) begin
					if (st_w[vi] == ST_M) begin
						bump[3] = 1'b1;
						req     = 1'b1;
						rkind   = REQ_WB;
						raddr   = wb64[31:0] & AMASK;
					end else if (st_w[vi] != ST_I) begin
						bump[2] = 1'b1;
					end
					ntag_w[vi] = itag;
				end
				nst_w[vi] = item_s1.fill_state;
				nlu_w[vi] = cyc;
				blocked_d = 1'b0;
				ready_d   = cyc + 32'd1;
			end
			default: ;
		endcase
		for (int w = 0; w < WAYS; w++) begin
			wrow[w*LINE_W +: LINE_W] = {nlu_w[w], nst_w[w], ntag_w[w]};
		end
		for (int k = 0; k < 5; k++) begin
			cnt_d[k] = sat_inc(cnt_q[k], bump[k]);
		end
		res                    = '0;
		res.access_done        = done;
		res.bus_req_valid      = req;
		res.bus_req_kind       = req ? rkind : 2'd0;
		res.bus_req_addr       = req ? raddr : 32'd0;
		res.bus_req_source     = req ? cache_id : '0;
		res.blocked            = blocked_d;
		res.ready_cycle        = ready_d;
		res.hit_count          = cnt_d[0];
		res.miss_count         = cnt_d[1];
		res.eviction_count     = cnt_d[2];
		res.writeback_count    = cnt_d[3];
		res.invalidation_count = cnt_d[4];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= q_item;
			set_s1  <= set_of(q_item.address);
		end
		if (exec) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			row_valid_q <= '0;
			blocked_q   <= 1'b0;
			ready_q     <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 5; k++) cnt_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (exec) begin
				row_valid_q[set_s1] <= 1'b1;
				blocked_q           <= blocked_d;
				ready_q             <= ready_d;
				for (int k = 0; k < 5; k++) cnt_q[k] <= cnt_d[k];
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
endmodule

@@ sv/mesi_snooping_cache_controller_top.sv @@
// MESI snooping cache tag/state store with timestamp LRU.
// s_axis: one item per transfer (processor access, snooped bus request or
//   fill completion). m_axis: exactly one result per item, in order.
// cfg: write of cache_id, always ready; write only while the block is idle.
// A front stage unpacks items into a two-entry queue; the back stage reads
// the set row from a single-port-read RAM, updates tags, states, LRU stamps,
// status and counters, writes the row back and loads the output register.
// From an input transfer with the back stage idle, the item is registered in
// the queue, popped with the RAM read, then the row update loads the output
// register. The back stage takes no new item before the last is through: RAM
// read, row update and write back, then the result transfer must finish before
// the next pop, which waits while m_axis_tready is low.
// Reset clears the queue, per-set valid bits (rows read as zero until first
// written), status and counters; no clearing pass is needed.
// When m_axis_tready is low the result holds, the back stage stops and the
// queue fills, then s_axis_tready drops.
module mesi_snooping_cache_controller_top #(
	parameter int SET_BITS    = msc_pkg::SET_BITS_D,
	parameter int WAYS        = msc_pkg::WAYS_D,
	parameter int OFFSET_BITS = msc_pkg::OFFSET_BITS_D,
	parameter int ADDR_BITS   = msc_pkg::ADDR_BITS_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// action, is_write, snoop_kind, address, current_cycle, fill_state
	input  logic [msc_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// access_done, bus_req_valid, bus_req_kind, bus_req_addr, bus_req_source,
	// blocked, ready_cycle, hit, miss, eviction, writeback, invalidation counts
	output logic [msc_pkg::OUT_W-1:0]  m_axis_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [msc_pkg::ID_W-1:0]   cfg_data
);
	import msc_pkg::*;

	logic            q_valid, pop;
	item_t           q_item;
	logic [ID_W-1:0] cache_id_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_id_q <= '0;
		end else if (cfg_valid) begin
			cache_id_q <= cfg_data;
		end
	end

	msc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.pop          (pop),
		.q_valid      (q_valid),
		.q_item       (q_item)
	);

	msc_back #(
		.SET_BITS   (SET_BITS),
		.WAYS       (WAYS),
		.OFFSET_BITS(OFFSET_BITS),
		.ADDR_BITS  (ADDR_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.cache_id     (cache_id_q),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);
endmodule

@@ sv/msc_checker.sv @@
module msc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic [msc_pkg::IN_W-1:0]  s_axis_tdata,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [msc_pkg::OUT_W-1:0] m_axis_tdata,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [msc_pkg::ID_W-1:0]  cfg_data
);
	import msc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_noreq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[39:2] == '0)
		else $error("request fields set without request");

	a_done_noreq: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
		else $error("hit with bus request");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[3:2] != 2'd3)
		else $error("bad request kind");
endmodule

bind mesi_snooping_cache_controller_top msc_checker u_chk (.*);
